### rtl/okm_pkg.sv
package okm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ACTIVE_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CLUSTERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CENTROIDS = 2'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DIVIDE,
    S_FINISH
  } okm_state_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } okm_div_stat_t;

endpackage

### rtl/online_kmeans_1d_update.sv
// Each sample passes through the serial nearest search over the clusters in use (one
// centroid a cycle), the restoring divider (one quotient bit a cycle) and the output register.
// A new sample is accepted only once the previous result has been loaded into the output
// register, since in_ready is high only in the idle state.
// Synchronous active-low reset: eight clusters, all centroids zero, all weights one.
module online_kmeans_1d_update #(
  parameter int unsigned MAX_CLUSTERS  = 8,
  parameter int unsigned COUNT_BITS    = 24,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_sample,
  input  logic                               in_end_of_batch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_cluster_index,
  output logic [15:0]                        out_new_centroid,
  output logic [23:0]                        out_new_count,
  output logic                               out_batch_done,
  input  logic                               cfg_we,
  input  logic [okm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [okm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import okm_pkg::*;

  localparam int unsigned CENT_W = 8 + FRACTION_BITS;
  localparam int unsigned IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned DVS_W  = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ACTIVE_W-1:0]   MAX_ACT   = ACTIVE_W'(MAX_CLUSTERS);

  okm_state_t state_r, state_nxt;

  logic [ACTIVE_W-1:0]   active_r;
  logic [CFG_DATA_W-1:0] init_r;
  logic [CENT_W-1:0]     cent_r [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0] wgt_r  [MAX_CLUSTERS];
  logic [CENT_W-1:0]     point_r;
  logic                  last_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_idx_r;
  logic [15:0]           out_cent_r;
  logic [23:0]           out_cnt_r;
  logic                  out_last_r;

  logic                  accept;
  logic                  out_load;
  logic                  cfg_hit;
  logic [CFG_DATA_W-1:0] init_src;
  logic [ACTIVE_W-1:0]   in_use;
  logic [IDX_W-1:0]      last_idx;

  logic [IDX_W-1:0]      k;
  logic                  srch_done;
  logic [IDX_W-1:0]      best_idx;
  logic [CENT_W-1:0]     best_cent;
  logic [COUNT_BITS-1:0] best_wgt;

  logic                  above;
  logic [CENT_W-1:0]     gap;
  logic [DVS_W-1:0]      divisor;
  logic [CENT_W-1:0]     quot;
  okm_div_stat_t         div_stat;
  logic [CENT_W-1:0]     mean;
  logic [COUNT_BITS-1:0] new_wgt;

  always_comb begin
    if (active_r == '0) begin
      in_use = ACTIVE_W'(1);
    end else if (active_r > MAX_ACT) begin
      in_use = MAX_ACT;
    end else begin
      in_use = active_r;
    end
    last_idx = IDX_W'(in_use - ACTIVE_W'(1));
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  okm_search #(
    .IDX_W  (IDX_W),
    .CENT_W (CENT_W),
    .CNT_W  (COUNT_BITS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .last_idx  (last_idx),
    .point     (point_r),
    .cent_k    (cent_r[k]),
    .wgt_k     (wgt_r[k]),
    .k         (k),
    .done      (srch_done),
    .best_idx  (best_idx),
    .best_cent (best_cent),
    .best_wgt  (best_wgt)
  );

  // The mean is c + (p - c) / (w + 1) rounded down, so only the gap is divided.
  always_comb begin
    above   = (point_r >= best_cent);
    gap     = above ? (point_r - best_cent) : (best_cent - point_r);
    divisor = {1'b0, best_wgt} + DVS_W'(1);
  end

  okm_divider #(
    .DVD_W (CENT_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_SEARCH) && srch_done),
    .dividend (gap),
    .divisor  (divisor),
    .quotient (quot),
    .stat     (div_stat)
  );

  always_comb begin
    if (above) begin
      mean = best_cent + quot;
    end else begin
      mean = best_cent - quot - CENT_W'(div_stat.rem_nz);
    end
    new_wgt = (best_wgt == COUNT_MAX) ? best_wgt : best_wgt + COUNT_BITS'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch_done) begin
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cfg_hit  = cfg_we && ((cfg_index == CFG_ACTIVE_CLUSTERS) ||
                               (cfg_index == CFG_INITIAL_CENTROIDS));
  assign init_src = (cfg_index == CFG_INITIAL_CENTROIDS) ? cfg_wdata : init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      init_r   <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cent_r[i] <= '0;
        wgt_r[i]  <= COUNT_BITS'(1);
      end
    end else if (cfg_hit) begin
      if (cfg_index == CFG_ACTIVE_CLUSTERS) begin
        active_r <= cfg_wdata[ACTIVE_W-1:0];
      end else begin
        init_r <= cfg_wdata;
      end
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cent_r[i] <= CENT_W'(init_src[8*i +: 8]) << FRACTION_BITS;
        wgt_r[i]  <= COUNT_BITS'(1);
      end
    end else if (out_load) begin
      cent_r[best_idx] <= mean;
      wgt_r[best_idx]  <= new_wgt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point_r <= CENT_W'(in_sample) << FRACTION_BITS;
      last_r  <= in_end_of_batch;
    end
    if (out_load) begin
      out_idx_r  <= 3'(best_idx);
      out_cent_r <= 16'(mean);
      out_cnt_r  <= 24'(new_wgt);
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cluster_index = out_idx_r;
  assign out_new_centroid  = out_cent_r;
  assign out_new_count     = out_cnt_r;
  assign out_batch_done    = out_last_r;

endmodule

### rtl/okm_search.sv
module okm_search #(
  parameter int unsigned IDX_W  = 3,
  parameter int unsigned CENT_W = 16,
  parameter int unsigned CNT_W  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IDX_W-1:0]  last_idx,
  input  logic [CENT_W-1:0] point,
  input  logic [CENT_W-1:0] cent_k,
  input  logic [CNT_W-1:0]  wgt_k,
  output logic [IDX_W-1:0]  k,
  output logic              done,
  output logic [IDX_W-1:0]  best_idx,
  output logic [CENT_W-1:0] best_cent,
  output logic [CNT_W-1:0]  best_wgt
);
  import okm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CENT_W-1:0] best_dist_r, best_dist_nxt;
  logic [CENT_W-1:0] best_cent_r, best_cent_nxt;
  logic [CNT_W-1:0]  best_wgt_r, best_wgt_nxt;
  logic [CENT_W-1:0] delta;
  logic              take;

  always_comb begin
    delta = (cent_k >= point) ? (cent_k - point) : (point - cent_k);
    take = (k_r == '0) || (delta < best_dist_r);
    busy_nxt      = busy_r;
    done_nxt      = 1'b0;
    k_nxt         = k_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    best_cent_nxt = best_cent_r;
    best_wgt_nxt  = best_wgt_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (take) begin
        best_idx_nxt  = k_r;
        best_dist_nxt = delta;
        best_cent_nxt = cent_k;
        best_wgt_nxt  = wgt_k;
      end
      if (k_r == last_idx) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_cent_r <= best_cent_nxt;
    best_wgt_r  <= best_wgt_nxt;
  end

  assign k         = k_r;
  assign done      = done_r;
  assign best_idx  = best_idx_r;
  assign best_cent = best_cent_r;
  assign best_wgt  = best_wgt_r;

endmodule

### rtl/okm_divider.sv
module okm_divider #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output okm_pkg::okm_div_stat_t stat
);
  import okm_pkg::*;

  localparam int unsigned WW  = (DVS_W > DVD_W + 1) ? DVS_W : DVD_W + 1;
  localparam int unsigned CW  = $clog2(DVD_W + 1);

  logic [WW-1:0]    dvs_ext;
  logic [DVD_W:0]   dvs_lo_r, dvs_lo_nxt;
  logic             big_r, big_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVD_W:0]   trial;
  logic [DVD_W:0]   diff;
  logic             ge;

  always_comb begin
    dvs_ext = WW'(divisor);
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - dvs_lo_r;
    ge      = !big_r && (trial >= dvs_lo_r);
    dvs_lo_nxt = dvs_lo_r;
    big_nxt    = big_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      dvs_lo_nxt = dvs_ext[DVD_W:0];
      big_nxt    = |(dvs_ext >> (DVD_W + 1));
      dvd_nxt    = dividend;
      rem_nxt    = '0;
      cnt_nxt    = CW'(DVD_W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_lo_r <= dvs_lo_nxt;
    big_r    <= big_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
  end

  assign quotient    = dvd_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = |rem_r;

endmodule
